### design/bod_pkg.sv
package bod_pkg;

	// Default number of entry cells.
	localparam int CAPACITY_DEF = 16;

	typedef enum logic [2:0] {
		CMD_PUSH_HEAD = 3'd0,
		CMD_PUSH_TAIL = 3'd1,
		CMD_INSERT    = 3'd2,
		CMD_POP_HEAD  = 3'd3,
		CMD_POP_TAIL  = 3'd4,
		CMD_REMOVE    = 3'd5,
		CMD_CLEAR     = 3'd6,
		CMD_SEARCH    = 3'd7
	} cmd_t;

	localparam logic [1:0] STS_DONE = 2'd0;
	localparam logic [1:0] STS_MISS = 2'd1;
	localparam logic [1:0] STS_FULL = 2'd2;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] operand_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic signed [31:0] popped_value;
		logic [4:0]         entry_count;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic compare;
		logic execute;
	} ctl_t;

endpackage

### design/bod_prefix_or.sv
// Inclusive prefix OR from bit 0 upward, built as a log-depth tree.
module bod_prefix_or #(
	parameter int WIDTH = bod_pkg::CAPACITY_DEF
) (
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	localparam int LEVELS = $clog2(WIDTH);

	logic [WIDTH-1:0] lvl [LEVELS+1];

	assign lvl[0] = din;

	for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
		localparam int STEP = 2 ** k;
		for (genvar i = 0; i < WIDTH; i++) begin : g_bit
			if (i >= STEP) begin : g_or
				assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-STEP];
			end else begin : g_pass
				assign lvl[k+1][i] = lvl[k][i];
			end
		end
	end

	assign dout = lvl[LEVELS];

endmodule

### design/bod_datapath.sv
// Entry cells, compare flags, shift control and the result register.
module bod_datapath #(
	parameter int CAPACITY = bod_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bod_pkg::ctl_t ctl,
	input  bod_pkg::req_t req,
	output bod_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [31:0] entries_q [CAPACITY];
	logic [CW-1:0]      occ_q;
	logic [CW-1:0]      occ_nxt;
	bod_pkg::cmd_t      cmd_q;
	logic signed [31:0] val_q;
	bod_pkg::rsp_t      rsp_q;

	logic [CAPACITY-1:0] ge_q, eq_q;
	logic [CAPACITY-1:0] valid, last, mid_ge, pm, pe;
	logic [CAPACITY-1:0] ins_after, after, take, pick, wr_oh, first_eq;

	logic               empty, full, ge_last, eq_last, hit;
	logic               shr, shl, found;
	logic [1:0]         status;
	logic signed [31:0] popped;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req.cmd;
			val_q <= req.operand_value;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] prev_v, next_v;

		assign valid[i] = CW'(i) < occ_q;

		if (i == CAPACITY - 1) begin : g_end
			assign last[i] = valid[i];
			assign next_v  = entries_q[i];
		end else begin : g_mid
			assign last[i] = valid[i] & ~valid[i+1];
			assign next_v  = entries_q[i+1];
		end

		if (i == 0) begin : g_first
			assign prev_v      = val_q;
			assign mid_ge[i]   = 1'b0;
			assign wr_oh[i]    = after[i];
			assign first_eq[i] = eq_q[i];
		end else begin : g_rest
			assign prev_v      = entries_q[i-1];
			assign mid_ge[i]   = valid[i] & ge_q[i];
			assign wr_oh[i]    = after[i] & ~after[i-1];
			assign first_eq[i] = eq_q[i] & ~pe[i-1];
		end

		always_ff @(posedge clk) begin
			if (ctl.compare) begin
				ge_q[i] <= entries_q[i] >= val_q;
				eq_q[i] <= valid[i] && (entries_q[i] == val_q);
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.execute) begin
				if (shr) begin
					if (wr_oh[i]) begin
						entries_q[i] <= val_q;
					end else if (after[i]) begin
						entries_q[i] <= prev_v;
					end
				end else if (shl && take[i]) begin
					entries_q[i] <= next_v;
				end
			end
		end
	end

	bod_prefix_or #(.WIDTH(CAPACITY)) u_pm (.din(mid_ge), .dout(pm));
	bod_prefix_or #(.WIDTH(CAPACITY)) u_pe (.din(eq_q), .dout(pe));

	assign empty   = occ_q == '0;
	assign full    = occ_q == CW'(CAPACITY);
	assign ge_last = |(ge_q & last);
	assign eq_last = |(eq_q & last);
	assign hit     = |eq_q;

	// Ordered insert: the cells at or after the insert point move toward the tail.
	// A head strictly above the operand sends the operand to the front.
	always_comb begin
		if (empty || (ge_q[0] && !eq_q[0])) begin
			ins_after = '1;
		end else if (ge_last && (|mid_ge)) begin
			ins_after = pm;
		end else begin
			ins_after = ~valid;
		end
	end

	always_comb begin
		shr     = 1'b0;
		shl     = 1'b0;
		after   = '0;
		take    = '0;
		pick    = '0;
		status  = bod_pkg::STS_DONE;
		found   = 1'b0;
		occ_nxt = occ_q;
		case (cmd_q)
			bod_pkg::CMD_PUSH_HEAD, bod_pkg::CMD_PUSH_TAIL, bod_pkg::CMD_INSERT: begin
				if (full) begin
					status = bod_pkg::STS_FULL;
				end else begin
					shr     = 1'b1;
					occ_nxt = occ_q + CW'(1);
					if (cmd_q == bod_pkg::CMD_PUSH_HEAD) begin
						after = '1;
					end else if (cmd_q == bod_pkg::CMD_PUSH_TAIL) begin
						after = ~valid;
					end else begin
						after = ins_after;
					end
				end
			end
			bod_pkg::CMD_POP_HEAD: begin
				if (empty) begin
					status = bod_pkg::STS_MISS;
				end else begin
					shl     = 1'b1;
					take    = '1;
					pick    = CAPACITY'(1);
					occ_nxt = occ_q - CW'(1);
				end
			end
			bod_pkg::CMD_POP_TAIL: begin
				if (empty) begin
					status = bod_pkg::STS_MISS;
				end else begin
					pick    = last;
					occ_nxt = occ_q - CW'(1);
				end
			end
			bod_pkg::CMD_REMOVE: begin
				if (hit) begin
					found   = 1'b1;
					occ_nxt = occ_q - CW'(1);
					if (!eq_q[0] && eq_last) begin
						pick = last;
					end else begin
						shl  = 1'b1;
						take = pe;
						pick = first_eq;
					end
				end else begin
					status = bod_pkg::STS_MISS;
				end
			end
			bod_pkg::CMD_CLEAR: begin
				occ_nxt = '0;
			end
			bod_pkg::CMD_SEARCH: begin
				found  = hit;
				status = hit ? bod_pkg::STS_DONE : bod_pkg::STS_MISS;
			end
			default: begin
				status = bod_pkg::STS_DONE;
			end
		endcase
	end

	always_comb begin
		popped = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (pick[i]) begin
				popped = popped | entries_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctl.execute) begin
			occ_q <= occ_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			rsp_q.status       <= status;
			rsp_q.found        <= found;
			rsp_q.popped_value <= popped;
			rsp_q.entry_count  <= 5'(occ_nxt);
		end
	end

	assign rsp = rsp_q;

endmodule

### design/bod_ctrl.sv
// Sequencer: take a command, register the compare flags, then apply it.
module bod_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bod_pkg::ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   accept, out_free;

	assign req_stall = !(state_q == S_IDLE || state_q == S_EXEC);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;

	always_comb begin
		state_nxt   = state_q;
		ctl.load    = accept;
		ctl.compare = 1'b0;
		ctl.execute = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = S_CMP;
				end
			end
			S_CMP: begin
				ctl.compare = 1'b1;
				if (out_free) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.execute = 1'b1;
				state_nxt   = accept ? S_CMP : S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.execute) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

### design/bounded_ordered_deque.sv
// The accepted command is registered, then its compare flags, then its result beat; a stalled
// result holds the compare step. Each command passes through a compare cycle and an apply cycle.
// A new command is taken during the apply cycle of the previous one.
// Reset: arst_n empties the store and idles the sequencer; entry cells are not cleared.
module bounded_ordered_deque #(
	parameter int CAPACITY = bod_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bod_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bod_pkg::rsp_t rsp
);

	// The store is a row of cells, head at cell zero. Every command runs in
	// two steps. In the compare step each cell compares its value with the
	// operand and the flags are registered. In the apply step prefix trees
	// over those flags find the insert or removal point, each cell loads its
	// neighbor, the operand or holds, and the result beat is registered.
	// The result register parts the two channels, so a waiting result does not block the next
	// command from being taken, though a stalled result holds that command in the compare step.

	bod_pkg::ctl_t ctl;

	bod_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl)
	);

	bod_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
